[sv/sip_pkg.sv]
// sip_pkg: shared types and constants for the segment intersection pipeline.
// No dependencies.
package sip_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int DEN_W     = 35;
  localparam int CROSS_W   = 33;
  localparam int NUM_W     = 51;
  localparam int N_W       = 64;
  localparam int D_W       = 36;
  localparam int Q_W       = 29;
  localparam int V_W       = 31;
  localparam int OUT_W     = 28;
  localparam int FRAC_W    = 16;
  localparam int TOL_W     = 8;
  localparam int FRONT_LAT = 7;
  localparam int DIV_LAT   = Q_W;
  localparam int BACK_LAT  = 3;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT;
  localparam int IN_DATA_W  = 8 * COORD_W;
  localparam int OUT_DATA_W = 64;

  // first endpoint field sits in the lowest bits of the request word
  typedef struct packed {
    logic signed [COORD_W-1:0] y4;
    logic signed [COORD_W-1:0] x4;
    logic signed [COORD_W-1:0] y3;
    logic signed [COORD_W-1:0] x3;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x1;
  } geom_t;

  typedef struct packed {
    logic miss;
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

[sv/sip_front.sv]
// sip_front: differences, determinants, numerators and divider operands.
// Seven register stages. Depends on sip_pkg.
module sip_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sip_pkg::IN_DATA_W-1:0] in_data,
  output sip_pkg::geom_t                geom,
  output sip_pkg::flags_t               flags,
  output logic [sip_pkg::N_W-1:0]       nx,
  output logic [sip_pkg::N_W-1:0]       ny,
  output logic [sip_pkg::D_W-1:0]       dd
);

  sip_pkg::geom_t g_in;
  sip_pkg::geom_t g_r [sip_pkg::FRONT_LAT];

  logic signed [sip_pkg::DIFF_W-1:0] dx12_1, dy12_1, dx34_1, dy34_1;
  logic signed [sip_pkg::DIFF_W-1:0] dx12_2, dy12_2, dx34_2, dy34_2;
  logic signed [sip_pkg::DIFF_W-1:0] dx12_3, dy12_3, dx34_3, dy34_3;
  logic signed [2*sip_pkg::DIFF_W-1:0] pa_2, pb_2;
  logic signed [2*sip_pkg::COORD_W-1:0] pc_2, pd_2, pe_2, pf_2;
  logic signed [sip_pkg::DEN_W-1:0] den_3, den_4, den_5, den_next;
  logic signed [sip_pkg::CROSS_W-1:0] pre_3, post_3;
  logic signed [sip_pkg::NUM_W-1:0] ma_4, mb_4, mc_4, me_4, numx_5, numy_5;
  logic [sip_pkg::NUM_W-1:0] magx, magy;
  logic [sip_pkg::DEN_W-1:0] magd;
  logic [sip_pkg::N_W-1:0] nx_6, ny_6;
  logic [sip_pkg::D_W-1:0] d_6;
  logic negx_6, negy_6, zero_6;
  logic [sip_pkg::N_W:0] dlim;

  assign g_in = in_data;
  assign den_next = 35'(pa_2) - 35'(pb_2);
  assign magx = numx_5[sip_pkg::NUM_W-1] ? 51'(-numx_5) : 51'(numx_5);
  assign magy = numy_5[sip_pkg::NUM_W-1] ? 51'(-numy_5) : 51'(numy_5);
  assign magd = den_5[sip_pkg::DEN_W-1] ? 35'(-den_5) : 35'(den_5);
  assign dlim = {d_6, 29'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0] <= g_in;
      for (int i = 1; i < sip_pkg::FRONT_LAT; i++) g_r[i] <= g_r[i-1];
      // stage 1
      dx12_1 <= 17'(g_in.x1) - 17'(g_in.x2);
      dy12_1 <= 17'(g_in.y1) - 17'(g_in.y2);
      dx34_1 <= 17'(g_in.x3) - 17'(g_in.x4);
      dy34_1 <= 17'(g_in.y3) - 17'(g_in.y4);
      // stage 2
      pa_2 <= 34'(dx12_1) * 34'(dy34_1);
      pb_2 <= 34'(dy12_1) * 34'(dx34_1);
      pc_2 <= 32'(g_r[0].x1) * 32'(g_r[0].y2);
      pd_2 <= 32'(g_r[0].y1) * 32'(g_r[0].x2);
      pe_2 <= 32'(g_r[0].x3) * 32'(g_r[0].y4);
      pf_2 <= 32'(g_r[0].y3) * 32'(g_r[0].x4);
      dx12_2 <= dx12_1;
      dy12_2 <= dy12_1;
      dx34_2 <= dx34_1;
      dy34_2 <= dy34_1;
      // stage 3
      den_3  <= den_next;
      pre_3  <= 33'(pc_2) - 33'(pd_2);
      post_3 <= 33'(pe_2) - 33'(pf_2);
      dx12_3 <= dx12_2;
      dy12_3 <= dy12_2;
      dx34_3 <= dx34_2;
      dy34_3 <= dy34_2;
      // stage 4
      ma_4  <= 51'(pre_3) * 51'(dx34_3);
      mb_4  <= 51'(dx12_3) * 51'(post_3);
      mc_4  <= 51'(pre_3) * 51'(dy34_3);
      me_4  <= 51'(dy12_3) * 51'(post_3);
      den_4 <= den_3;
      // stage 5
      numx_5 <= ma_4 - mb_4;
      numy_5 <= mc_4 - me_4;
      den_5  <= den_4;
      // stage 6: N = 2*|num|*4096 + |den|, D = 2*|den|
      nx_6   <= {magx, 13'b0} + 64'(magd);
      ny_6   <= {magy, 13'b0} + 64'(magd);
      d_6    <= {magd, 1'b0};
      negx_6 <= numx_5[sip_pkg::NUM_W-1] ^ den_5[sip_pkg::DEN_W-1];
      negy_6 <= numy_5[sip_pkg::NUM_W-1] ^ den_5[sip_pkg::DEN_W-1];
      zero_6 <= (den_5 == '0);
      // stage 7: quotient too large for Q_W bits is a sure miss
      nx    <= nx_6;
      ny    <= ny_6;
      dd    <= d_6;
      flags.miss  <= zero_6 || ({1'b0, nx_6} >= dlim) || ({1'b0, ny_6} >= dlim);
      flags.neg_x <= negx_6;
      flags.neg_y <= negy_6;
    end
  end

  assign geom = g_r[sip_pkg::FRONT_LAT-1];

endmodule

[sv/sip_div.sv]
// sip_div: pipelined restoring divider, one quotient bit per stage.
// Depends on sip_pkg.
module sip_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [sip_pkg::N_W-1:0] n,
  input  logic [sip_pkg::D_W-1:0] d,
  output logic [sip_pkg::Q_W-1:0] q
);

  logic [sip_pkg::N_W-1:0] rem_r [sip_pkg::DIV_LAT];
  logic [sip_pkg::D_W-1:0] d_r   [sip_pkg::DIV_LAT];
  logic [sip_pkg::Q_W-1:0] q_r   [sip_pkg::DIV_LAT];

  for (genvar i = 0; i < sip_pkg::DIV_LAT; i++) begin : g_stage
    localparam int K = sip_pkg::Q_W - 1 - i;
    logic [sip_pkg::N_W-1:0] rem_i, dk;
    logic [sip_pkg::D_W-1:0] d_i;
    logic [sip_pkg::Q_W-1:0] q_i;
    logic ge;

    if (i == 0) begin : g_first
      assign rem_i = n;
      assign d_i   = d;
      assign q_i   = '0;
    end else begin : g_rest
      assign rem_i = rem_r[i-1];
      assign d_i   = d_r[i-1];
      assign q_i   = q_r[i-1];
    end

    assign dk = 64'(d_i) << K;
    assign ge = rem_i >= dk;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? rem_i - dk : rem_i;
        d_r[i]   <= d_i;
        q_r[i]   <= {q_i[sip_pkg::Q_W-2:0], ge};
      end
    end
  end

  assign q = q_r[sip_pkg::DIV_LAT-1];

endmodule

[sv/sip_back.sv]
// sip_back: sign, snap to whole numbers, bound checks and output register.
// Three register stages. Depends on sip_pkg.
module sip_back (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sip_pkg::TOL_W-1:0]     tol,
  input  logic [sip_pkg::Q_W-1:0]       qx,
  input  logic [sip_pkg::Q_W-1:0]       qy,
  input  sip_pkg::geom_t                geom,
  input  sip_pkg::flags_t               flags,
  output logic                          hit,
  output logic [sip_pkg::OUT_W-1:0]     cross_x,
  output logic [sip_pkg::OUT_W-1:0]     cross_y
);

  function automatic logic signed [sip_pkg::V_W-1:0] snap(
    input logic signed [sip_pkg::V_W-1:0] v,
    input logic [sip_pkg::TOL_W-1:0]      t
  );
    logic [sip_pkg::FRAC_W-1:0] f;
    logic [sip_pkg::FRAC_W:0]   c;
    logic signed [sip_pkg::V_W-1:0] fl;
    f  = v[sip_pkg::FRAC_W-1:0];
    c  = 17'h10000 - 17'(f);
    fl = {v[sip_pkg::V_W-1:sip_pkg::FRAC_W], 16'b0};
    if (f == '0) begin
      snap = v;
    end else if ((17'(f) < 17'(t)) || (c < 17'(t))) begin
      snap = (17'(f) <= c) ? fl : fl + 31'sh10000;
    end else begin
      snap = v;
    end
  endfunction

  function automatic logic in_rng(
    input logic signed [sip_pkg::V_W-1:0]     v,
    input logic signed [sip_pkg::COORD_W-1:0] a,
    input logic signed [sip_pkg::COORD_W-1:0] b
  );
    logic signed [sip_pkg::COORD_W-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    in_rng = (v >= (31'(lo) <<< 12)) && (v <= (31'(hi) <<< 12));
  endfunction

  logic signed [sip_pkg::V_W-1:0] vx, vy, sx_1, sy_1, sx_2, sy_2;
  sip_pkg::geom_t g_1;
  logic miss_1, hit_2;

  assign vx = flags.neg_x ? -31'({2'b0, qx}) : 31'({2'b0, qx});
  assign vy = flags.neg_y ? -31'({2'b0, qy}) : 31'({2'b0, qy});

  always_ff @(posedge clk) begin
    if (en) begin
      sx_1   <= snap(vx, tol);
      sy_1   <= snap(vy, tol);
      g_1    <= geom;
      miss_1 <= flags.miss;
      sx_2   <= sx_1;
      sy_2   <= sy_1;
      hit_2  <= !miss_1 && in_rng(sx_1, g_1.x1, g_1.x2) && in_rng(sx_1, g_1.x3, g_1.x4)
                && in_rng(sy_1, g_1.y1, g_1.y2) && in_rng(sy_1, g_1.y3, g_1.y4);
      hit     <= hit_2;
      cross_x <= hit_2 ? sx_2[sip_pkg::OUT_W-1:0] : '0;
      cross_y <= hit_2 ? sy_2[sip_pkg::OUT_W-1:0] : '0;
    end
  end

endmodule

[sv/segment_intersection_point.sv]
// segment_intersection_point: top level of the segment crossing pipeline.
// Depends on sip_pkg, sip_front, sip_div, sip_back.
//
//  channel   direction  contents
//  s_axis    in         two segments, Q12.4 endpoints
//  m_axis    out        hit flag, crossing point Q12.16
//  cfg       in         snap_tolerance
//
// One request per cycle while m_axis does not stall; 7 front stages (multiplies),
// 29 divider stages (one quotient bit each) and 3 back stages.
// Synchronous reset clears the valid line and sets snap_tolerance to 7.
// A stall on m_axis holds every stage; s_tready follows it combinationally.
module segment_intersection_point (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y (16 bits each)
  input  logic [sip_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // cross_x [27:0], cross_y [55:28], zero [63:56]
  output logic [sip_pkg::OUT_DATA_W-1:0] m_tdata,
  // hit
  output logic                           m_tuser,
  input  logic                           cfg_wr_en,
  input  logic [sip_pkg::TOL_W-1:0]      cfg_wr_data
);

  logic [sip_pkg::PIPE_LAT-1:0] vld;
  logic [sip_pkg::TOL_W-1:0] snap_tolerance;
  logic en;

  sip_pkg::geom_t  geom_f, geom_d [sip_pkg::DIV_LAT];
  sip_pkg::flags_t flags_f, flags_d [sip_pkg::DIV_LAT];
  logic [sip_pkg::N_W-1:0] nx, ny;
  logic [sip_pkg::D_W-1:0] dd;
  logic [sip_pkg::Q_W-1:0] qx, qy;
  logic [sip_pkg::OUT_W-1:0] cross_x, cross_y;

  assign en       = !vld[sip_pkg::PIPE_LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[sip_pkg::PIPE_LAT-1];
  assign m_tdata  = {8'b0, cross_y, cross_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= '0;
      snap_tolerance <= 8'd7;
    end else begin
      if (en) vld <= {vld[sip_pkg::PIPE_LAT-2:0], s_tvalid};
      if (cfg_wr_en) snap_tolerance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geom_d[0]  <= geom_f;
      flags_d[0] <= flags_f;
      for (int i = 1; i < sip_pkg::DIV_LAT; i++) begin
        geom_d[i]  <= geom_d[i-1];
        flags_d[i] <= flags_d[i-1];
      end
    end
  end

  sip_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (s_tdata),
    .geom    (geom_f),
    .flags   (flags_f),
    .nx      (nx),
    .ny      (ny),
    .dd      (dd)
  );

  sip_div u_div_x (.clk(clk), .en(en), .n(nx), .d(dd), .q(qx));
  sip_div u_div_y (.clk(clk), .en(en), .n(ny), .d(dd), .q(qy));

  sip_back u_back (
    .clk     (clk),
    .en      (en),
    .tol     (snap_tolerance),
    .qx      (qx),
    .qy      (qy),
    .geom    (geom_d[sip_pkg::DIV_LAT-1]),
    .flags   (flags_d[sip_pkg::DIV_LAT-1]),
    .hit     (m_tuser),
    .cross_x (cross_x),
    .cross_y (cross_y)
  );

endmodule

[sv/sip_checker.sv]
// sip_checker: port-level checks on segment_intersection_point, bound in.
// Depends on segment_intersection_point.
module sip_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output request dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    else $error("miss with nonzero point");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:56] == 8'd0)
    else $error("padding bits set");

endmodule

bind segment_intersection_point sip_port_checks u_sip_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
